FILE: rtl/core/sorted_list_insert_search_delete_assert.svh
// Assertion helpers for the sorted list RTL
`ifndef SORTED_LIST_INSERT_SEARCH_DELETE_ASSERT_SVH
`define SORTED_LIST_INSERT_SEARCH_DELETE_ASSERT_SVH

// Same-cycle implication, checked on every rising edge out of reset
`define SLS_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("sls assertion failed");

// Next-cycle implication, checked on every rising edge out of reset
`define SLS_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("sls assertion failed");

`endif

FILE: rtl/core/sls_pkg.sv
package sls_pkg;

    // List size and derived widths
    localparam int CAPACITY = 128;
    localparam int CW       = $clog2(CAPACITY + 1);   // entry count, 0..CAPACITY
    localparam int IW       = $clog2(CAPACITY);       // cell index
    localparam int GROUP    = 16;                     // cells per first-level OR group
    localparam int NGRP     = (CAPACITY + GROUP - 1) / GROUP;
    localparam int XW       = (CW > 8) ? CW : 8;

    // Operation codes
    localparam logic [1:0] MODE_INSERT = 2'd0;
    localparam logic [1:0] MODE_SEARCH = 2'd1;
    localparam logic [1:0] MODE_DELETE = 2'd2;
    localparam logic [1:0] MODE_MEDIAN = 2'd3;

    // Status codes
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_FULL      = 2'd1;
    localparam logic [1:0] ST_NOT_FOUND = 2'd2;
    localparam logic [1:0] ST_EMPTY     = 2'd3;

    // Control broadcast from the sequencer to every cell
    typedef struct packed {
        logic                 cmp;    // load compare flags
        logic                 ins;    // apply insert shift
        logic                 del;    // apply delete shift
        logic                 med;    // select median cell instead of boundary
        logic signed [31:0]   val;
        logic [CW-1:0]        count;
        logic [IW-1:0]        mid;
    } t_cell_ctl;

    // Word a selected cell reports back
    typedef struct packed {
        logic                 found;
        logic [IW-1:0]        idx;
        logic signed [31:0]   value;
    } t_tap;

    // Count-width value to an 8-bit result field
    function automatic logic [7:0] to_b8(input logic [CW-1:0] x);
        logic [XW-1:0] t;
        t = XW'(x);
        return t[7:0];
    endfunction

endpackage

FILE: rtl/core/sls_cell.sv
module sls_cell (
    input  logic                   i_clk,
    input  sls_pkg::t_cell_ctl     i_ctl,
    input  logic [sls_pkg::IW-1:0] i_idx,
    input  logic                   i_left_lt,
    input  logic signed [31:0]     i_left_entry,
    input  logic signed [31:0]     i_right_entry,
    output logic                   o_lt,
    output logic signed [31:0]     o_entry,
    output sls_pkg::t_tap          o_tap
);
    import sls_pkg::*;

    logic signed [31:0] r_entry;
    logic               r_lt;
    logic               r_eq;
    logic               w_live;
    logic               w_mid;
    logic               w_bnd;
    logic               w_sel;

    // Boundary: first cell not below the operand (insert slot / first match)
    always_comb begin
        w_live = (CW'(i_idx) < i_ctl.count);
        w_mid  = (i_idx == i_ctl.mid);
        w_bnd  = !r_lt && i_left_lt;
        w_sel  = i_ctl.med ? w_mid : w_bnd;
    end

    always_comb begin
        if (w_sel) begin
            o_tap.found = r_eq;
            o_tap.idx   = i_idx;
            o_tap.value = r_entry;
        end else begin
            o_tap = '0;
        end
    end

    assign o_lt    = r_lt;
    assign o_entry = r_entry;

    // Compare flags, then shift toward or away from the boundary
    always_ff @(posedge i_clk) begin
        if (i_ctl.cmp) begin
            r_lt <= w_live && ($signed(r_entry) < $signed(i_ctl.val));
            r_eq <= w_live && (r_entry == i_ctl.val);
        end
        if (i_ctl.ins) begin
            if (w_bnd) begin
                r_entry <= i_ctl.val;
            end else if (!r_lt) begin
                r_entry <= i_left_entry;
            end
        end else if (i_ctl.del && !r_lt) begin
            r_entry <= i_right_entry;
        end
    end

endmodule

FILE: rtl/core/sls_chain.sv
module sls_chain (
    input  logic               i_clk,
    input  sls_pkg::t_cell_ctl i_ctl,
    output sls_pkg::t_tap      o_grp [sls_pkg::NGRP]
);
    import sls_pkg::*;

    localparam int TW = $bits(t_tap);

    logic               w_lt    [CAPACITY];
    logic signed [31:0] w_entry [CAPACITY];
    t_tap               w_tap   [CAPACITY];
    logic [TW-1:0]      w_pad   [NGRP*GROUP];
    t_tap               r_grp   [NGRP];

    // Row of cells, each wired to its neighbors
    for (genvar k = 0; k < CAPACITY; k++) begin : g_cell
        logic               w_left_lt;
        logic signed [31:0] w_left_entry;
        logic signed [31:0] w_right_entry;

        if (k == 0) begin : g_first
            assign w_left_lt    = 1'b1;
            assign w_left_entry = w_entry[k];
        end else begin : g_mid
            assign w_left_lt    = w_lt[k-1];
            assign w_left_entry = w_entry[k-1];
        end

        if (k == CAPACITY - 1) begin : g_last
            assign w_right_entry = w_entry[k];
        end else begin : g_inner
            assign w_right_entry = w_entry[k+1];
        end

        sls_cell u_cell (
            .i_clk         (i_clk),
            .i_ctl         (i_ctl),
            .i_idx         (IW'(k)),
            .i_left_lt     (w_left_lt),
            .i_left_entry  (w_left_entry),
            .i_right_entry (w_right_entry),
            .o_lt          (w_lt[k]),
            .o_entry       (w_entry[k]),
            .o_tap         (w_tap[k])
        );
    end

    // Pad the tap row to whole groups
    for (genvar p = 0; p < NGRP*GROUP; p++) begin : g_pad
        if (p < CAPACITY) begin : g_real
            assign w_pad[p] = w_tap[p];
        end else begin : g_zero
            assign w_pad[p] = '0;
        end
    end

    // First level of the registered OR tree: at most one cell is selected
    for (genvar g = 0; g < NGRP; g++) begin : g_grp
        logic [TW-1:0] w_acc;
        always_comb begin
            w_acc = '0;
            for (int j = 0; j < GROUP; j++) begin
                w_acc = w_acc | w_pad[g*GROUP + j];
            end
        end
        always_ff @(posedge i_clk) begin
            r_grp[g] <= w_acc;
        end
        assign o_grp[g] = r_grp[g];
    end

endmodule

FILE: rtl/core/sorted_list_insert_search_delete.sv
// Channel   Direction  Ports                       Content
// s_axis    in         i_s_axis_tvalid/o_..tready  tuser: mode; tdata: value
// m_axis    out        o_m_axis_tvalid/i_..tready  tdata: found, position, median, status, total
//
// Each item passes through accept, cell compare, group OR, final OR and commit, in that order.
// The OR tree over the cell row has two levels, whatever the list length.
// Commit waits while the output register holds an untaken result.
// A new item is taken while a result waits in the output register.
// Synchronous active-low reset empties the list at once (count to zero); no clearing pass.
`include "sorted_list_insert_search_delete_assert.svh"

module sorted_list_insert_search_delete (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [31:0] i_s_axis_tdata,   // [31:0] value
    input  logic [1:0]  i_s_axis_tuser,   // [1:0] mode
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [55:0] o_m_axis_tdata    // [0] found, [8:1] position, [40:9] median_value,
                                          // [42:41] status, [50:43] entry_total
);
    import sls_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CMP,
        S_GRP,
        S_TOT,
        S_DONE
    } t_state;

    t_state             r_state, n_state;
    logic [CW-1:0]      r_count, n_count;
    logic               r_m_valid, n_m_valid;
    logic [55:0]        r_m_data, n_m_data;
    logic [1:0]         r_mode;
    logic signed [31:0] r_val;
    t_tap               r_tap;
    t_tap               w_tot;
    t_tap               w_grp [NGRP];
    t_cell_ctl          w_ctl;
    logic               w_accept;
    logic               w_out_free;
    logic               w_ins;
    logic               w_del;
    logic               w_found;
    logic [CW-1:0]      w_pos;
    logic [CW-1:0]      w_hit_pos;
    logic signed [31:0] w_med;
    logic [1:0]         w_status;
    logic [CW:0]        w_cnt_inc;
    logic [CW-1:0]      w_half;

    // No item is taken while reset is held
    assign o_s_axis_tready = (r_state == S_IDLE) && i_rst_n;
    assign w_accept        = i_s_axis_tvalid && o_s_axis_tready;
    assign w_out_free      = !r_m_valid || i_m_axis_tready;
    assign o_m_axis_tvalid = r_m_valid;
    assign o_m_axis_tdata  = r_m_data;

    // Lower median sits at index ceil(count/2) - 1
    assign w_cnt_inc = {1'b0, r_count} + (CW+1)'(1);
    assign w_half    = w_cnt_inc[CW:1];
    assign w_hit_pos = CW'(r_tap.idx) + CW'(1);

    // Broadcast to the cell row
    always_comb begin
        w_ctl.cmp   = (r_state == S_CMP);
        w_ctl.ins   = w_ins;
        w_ctl.del   = w_del;
        w_ctl.med   = (r_mode == MODE_MEDIAN);
        w_ctl.val   = r_val;
        w_ctl.count = r_count;
        w_ctl.mid   = IW'(w_half - CW'(1));
    end

    sls_chain u_chain (
        .i_clk (i_clk),
        .i_ctl (w_ctl),
        .o_grp (w_grp)
    );

    // Second level of the OR tree
    always_comb begin
        w_tot = '0;
        for (int g = 0; g < NGRP; g++) begin
            w_tot = w_tot | w_grp[g];
        end
    end

    // Result of the operation, applied in the commit cycle
    always_comb begin
        w_ins    = 1'b0;
        w_del    = 1'b0;
        w_found  = 1'b0;
        w_pos    = '0;
        w_med    = '0;
        w_status = ST_OK;
        n_count  = r_count;
        unique case (r_mode) inside
            MODE_INSERT: begin
                if (r_count >= CW'(CAPACITY)) begin
                    w_status = ST_FULL;
                end else begin
                    w_pos   = w_hit_pos;
                    w_ins   = (r_state == S_DONE) && w_out_free;
                    n_count = r_count + CW'(1);
                end
            end
            MODE_SEARCH, MODE_DELETE: begin
                if (r_tap.found) begin
                    w_found = 1'b1;
                    w_pos   = w_hit_pos;
                    if (r_mode == MODE_DELETE) begin
                        w_del   = (r_state == S_DONE) && w_out_free;
                        n_count = r_count - CW'(1);
                    end
                end else begin
                    w_status = ST_NOT_FOUND;
                end
            end
            MODE_MEDIAN: begin
                if (r_count == '0) begin
                    w_status = ST_EMPTY;
                end else begin
                    w_med = r_tap.value;
                end
            end
            default: w_status = ST_OK;
        endcase
    end

    // Sequencer next state and output register
    always_comb begin
        n_state   = r_state;
        n_m_valid = r_m_valid;
        n_m_data  = r_m_data;
        if (r_m_valid && i_m_axis_tready) begin
            n_m_valid = 1'b0;
        end
        unique case (r_state)
            S_IDLE: if (w_accept) n_state = S_CMP;
            S_CMP:  n_state = S_GRP;
            S_GRP:  n_state = S_TOT;
            S_TOT:  n_state = S_DONE;
            S_DONE: begin
                if (w_out_free) begin
                    n_state   = S_IDLE;
                    n_m_valid = 1'b1;
                    n_m_data  = {5'd0, to_b8(n_count), w_status, w_med,
                                 to_b8(w_pos), w_found};
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_count   <= '0;
            r_m_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_m_valid <= n_m_valid;
            r_m_data  <= n_m_data;
            if (r_state == S_DONE && w_out_free) begin
                r_count <= n_count;
            end
            if (w_accept) begin
                r_mode <= i_s_axis_tuser;
                r_val  <= i_s_axis_tdata;
            end
            if (r_state == S_TOT) begin
                r_tap <= w_tot;
            end
        end
    end

    // Checks
    `SLS_ASSERT_NOW(a_count_cap, 1'b1, r_count <= CW'(CAPACITY))
    `SLS_ASSERT_NEXT(a_accept_cmp, w_accept, r_state == S_CMP)
    `SLS_ASSERT_NOW(a_del_match, w_del, r_tap.found && (r_count != '0))
    `SLS_ASSERT_NEXT(a_ins_grow, w_ins, r_count == $past(r_count) + CW'(1))
    `SLS_ASSERT_NEXT(a_commit_out, (r_state == S_DONE) && w_out_free, r_m_valid)

endmodule
